// ----- design/smfd_pkg.sv -----
// ----------------------------------------------------------------------------
// smfd_pkg: shared definitions for the measurement frame decoder
// Frame layout codes, CRC-8 constants, fixed-point scale factors and the
// types passed between the decoder modules.
// ----------------------------------------------------------------------------
package smfd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  pos_t;
  typedef logic [15:0] raw_word_t;
  typedef logic signed [14:0] temp_centi_t;
  typedef logic [13:0] hum_centi_t;

  // Response framing: three words, each two data bytes and one CRC byte
  localparam pos_t FRAME_BYTES = 4'd9;
  localparam pos_t LAST_POS    = 4'd8;

  // Byte role within a word group
  localparam logic [1:0] PH_MSB = 2'd0;
  localparam logic [1:0] PH_LSB = 2'd1;
  localparam logic [1:0] PH_CRC = 2'd2;

  // Word select masks, also the fresh flag bits
  localparam logic [2:0] WORD_CO2  = 3'b001;
  localparam logic [2:0] WORD_TEMP = 3'b010;
  localparam logic [2:0] WORD_HUM  = 3'b100;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no reflection, no final xor
  localparam byte_t CRC_POLY = 8'h31;
  localparam byte_t CRC_INIT = 8'hFF;

  // Fixed-point conversions: result = ((scale * raw) >> 16) - offset
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam temp_centi_t TEMP_OFFSET = 15'sd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam hum_centi_t  HUM_MAX     = 14'd9999;
  localparam temp_centi_t TEMP_MIN    = -15'sd4500;

  // Converted readings of one raw word
  typedef struct packed {
    temp_centi_t temperature;
    hum_centi_t  humidity;
  } scaled_t;

endpackage

// ----- design/smfd_in_if.sv -----
// ----------------------------------------------------------------------------
// smfd_in_if: response byte channel
// Valid/ready channel carrying one received byte and its frame start mark.
// ----------------------------------------------------------------------------
interface smfd_in_if;
  logic          valid;
  logic          ready;
  smfd_pkg::byte_t byte_value;
  logic          frame_start;

  modport source (output valid, output byte_value, output frame_start, input ready);
  modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

// ----- design/smfd_out_if.sv -----
// ----------------------------------------------------------------------------
// smfd_out_if: decoded measurement channel
// Valid/ready channel carrying the three held readings and their fresh flags.
// ----------------------------------------------------------------------------
interface smfd_out_if;
  logic                    valid;
  logic                    ready;
  smfd_pkg::raw_word_t     co2_ppm;
  smfd_pkg::temp_centi_t   temperature_centi;
  smfd_pkg::hum_centi_t    humidity_centi;
  logic                    co2_fresh;
  logic                    temperature_fresh;
  logic                    humidity_fresh;

  modport source (output valid, output co2_ppm, output temperature_centi,
                  output humidity_centi, output co2_fresh, output temperature_fresh,
                  output humidity_fresh, input ready);
  modport sink   (input valid, input co2_ppm, input temperature_centi,
                  input humidity_centi, input co2_fresh, input temperature_fresh,
                  input humidity_fresh, output ready);
endinterface

// ----- design/smfd_crc8.sv -----
// ----------------------------------------------------------------------------
// smfd_crc8: one-byte CRC-8 update
// Folds one data byte into a running CRC, MSB first, eight shift steps.
// ----------------------------------------------------------------------------
module smfd_crc8 (
  input  smfd_pkg::byte_t crc_in,
  input  smfd_pkg::byte_t data_in,
  output smfd_pkg::byte_t crc_out
);

  // Unrolled bitwise division, one step per data bit
  always_comb begin
    smfd_pkg::byte_t acc;
    acc = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if (acc[7]) begin
        acc = {acc[6:0], 1'b0} ^ smfd_pkg::CRC_POLY;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

// ----- design/smfd_scale.sv -----
// ----------------------------------------------------------------------------
// smfd_scale: raw word to engineering units
// Temperature in 0.01 degC and humidity in 0.01 %RH from a 16-bit raw word,
// each a constant multiply and floor shift of 16, temperature minus an offset.
// ----------------------------------------------------------------------------
module smfd_scale (
  input  smfd_pkg::raw_word_t raw,
  output smfd_pkg::scaled_t   scaled
);

  logic [30:0] temp_prod;
  logic [29:0] hum_prod;

  // Multiply by the scale constants
  assign temp_prod = 31'(raw) * 31'(smfd_pkg::TEMP_SCALE);
  assign hum_prod  = 30'(raw) * 30'(smfd_pkg::HUM_SCALE);

  // Keep the integer part; the temperature quotient stays below 17500 and
  // fills 15 bits, so the 15-bit difference with the offset lands in range
  assign scaled.temperature = $signed(temp_prod[30:16]) - smfd_pkg::TEMP_OFFSET;
  assign scaled.humidity    = hum_prod[29:16];

endmodule

// ----- design/sensor_measurement_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// sensor_measurement_frame_decoder: CRC-checked measurement frame decoder
// Takes a 9-byte response one byte at a time, checks each 16-bit reading
// against its CRC-8 and emits CO2, temperature and humidity after the last
// byte, with one fresh flag per reading.
// ----------------------------------------------------------------------------
// Path: the ninth byte passes the input register, then the result register.
// Throughput: one byte per cycle, set by the single decode stage, except
// that a frame's last byte waits while a result is pending; the output
// register lets the next frame flow while a result waits.
// Reset (rst_n low, synchronous): channels empty, byte position zero,
// CRC at 0xFF, held readings and fresh flags zero.
module sensor_measurement_frame_decoder (
  input logic        clk,
  input logic        rst_n,
  smfd_in_if.sink    in_ch,
  smfd_out_if.source out_ch
);

  // Input register
  logic                in_valid_r;
  smfd_pkg::byte_t     in_byte_r;
  logic                in_start_r;

  // Decoder state
  smfd_pkg::pos_t      pos_r, pos_nxt;
  smfd_pkg::byte_t     crc_r, crc_nxt;
  smfd_pkg::raw_word_t wbuf_r, wbuf_nxt;
  smfd_pkg::raw_word_t co2_r, co2_nxt;
  smfd_pkg::temp_centi_t temp_r, temp_nxt;
  smfd_pkg::hum_centi_t  hum_r, hum_nxt;
  logic [2:0]          fresh_r, fresh_nxt;

  // Result register
  logic                out_valid_r;
  smfd_pkg::raw_word_t out_co2_r;
  smfd_pkg::temp_centi_t out_temp_r;
  smfd_pkg::hum_centi_t  out_hum_r;
  logic [2:0]          out_fresh_r;

  // Decode stage signals
  smfd_pkg::pos_t      pos_cur;
  logic [1:0]          phase;
  logic [2:0]          word_sel;
  smfd_pkg::byte_t     crc_seed;
  smfd_pkg::byte_t     crc_calc;
  smfd_pkg::scaled_t   scaled;
  logic                crc_ok;
  logic                is_last;
  logic                dec_fire;
  logic                in_fire;
  logic                out_load;

  // Decode a held byte; a frame's last byte waits until the result register can take it
  assign is_last  = (pos_cur == smfd_pkg::LAST_POS);
  assign dec_fire = in_valid_r && (!is_last || !out_valid_r || out_ch.ready);
  assign out_load = dec_fire && is_last;

  assign in_ch.ready = !in_valid_r || dec_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Hold the incoming byte in the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (dec_fire) begin
      in_valid_r <= 1'b0;
    end
    if (in_fire) begin
      in_byte_r  <= in_ch.byte_value;
      in_start_r <= in_ch.frame_start;
    end
  end

  // Restart the frame on a start mark or an out-of-range position
  assign pos_cur = (in_start_r || (pos_r >= smfd_pkg::FRAME_BYTES)) ? '0 : pos_r;

  // Map the byte position to its role and word
  always_comb begin
    case (pos_cur)
      4'd0:    begin phase = smfd_pkg::PH_MSB; word_sel = smfd_pkg::WORD_CO2;  end
      4'd1:    begin phase = smfd_pkg::PH_LSB; word_sel = smfd_pkg::WORD_CO2;  end
      4'd2:    begin phase = smfd_pkg::PH_CRC; word_sel = smfd_pkg::WORD_CO2;  end
      4'd3:    begin phase = smfd_pkg::PH_MSB; word_sel = smfd_pkg::WORD_TEMP; end
      4'd4:    begin phase = smfd_pkg::PH_LSB; word_sel = smfd_pkg::WORD_TEMP; end
      4'd5:    begin phase = smfd_pkg::PH_CRC; word_sel = smfd_pkg::WORD_TEMP; end
      4'd6:    begin phase = smfd_pkg::PH_MSB; word_sel = smfd_pkg::WORD_HUM;  end
      4'd7:    begin phase = smfd_pkg::PH_LSB; word_sel = smfd_pkg::WORD_HUM;  end
      4'd8:    begin phase = smfd_pkg::PH_CRC; word_sel = smfd_pkg::WORD_HUM;  end
      default: begin phase = smfd_pkg::PH_MSB; word_sel = smfd_pkg::WORD_CO2;  end
    endcase
  end

  // Advance the running CRC; the first byte of a word starts from the seed
  assign crc_seed = (phase == smfd_pkg::PH_MSB) ? smfd_pkg::CRC_INIT : crc_r;

  smfd_crc8 u_crc8 (
    .crc_in  (crc_seed),
    .data_in (in_byte_r),
    .crc_out (crc_calc)
  );

  // Convert the buffered word in parallel with the CRC compare
  smfd_scale u_scale (
    .raw    (wbuf_r),
    .scaled (scaled)
  );

  assign crc_ok = (phase == smfd_pkg::PH_CRC) && (in_byte_r == crc_r);

  // Next decoder state
  always_comb begin
    crc_nxt   = crc_r;
    wbuf_nxt  = wbuf_r;
    co2_nxt   = co2_r;
    temp_nxt  = temp_r;
    hum_nxt   = hum_r;
    fresh_nxt = (pos_cur == '0) ? 3'b000 : fresh_r;
    case (phase)
      smfd_pkg::PH_MSB: begin
        crc_nxt  = crc_calc;
        wbuf_nxt = {in_byte_r, 8'h00};
      end
      smfd_pkg::PH_LSB: begin
        crc_nxt  = crc_calc;
        wbuf_nxt = {wbuf_r[15:8], in_byte_r};
      end
      smfd_pkg::PH_CRC: begin
        if (crc_ok) begin
          if (word_sel == smfd_pkg::WORD_CO2)  co2_nxt  = wbuf_r;
          if (word_sel == smfd_pkg::WORD_TEMP) temp_nxt = scaled.temperature;
          if (word_sel == smfd_pkg::WORD_HUM)  hum_nxt  = scaled.humidity;
          fresh_nxt = fresh_nxt | word_sel;
        end
      end
      default: begin
        crc_nxt = crc_r;
      end
    endcase
    pos_nxt = is_last ? '0 : pos_cur + 4'd1;
  end

  // Update decoder state on each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= smfd_pkg::CRC_INIT;
      wbuf_r  <= '0;
      co2_r   <= '0;
      temp_r  <= '0;
      hum_r   <= '0;
      fresh_r <= '0;
    end else if (dec_fire) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      wbuf_r  <= wbuf_nxt;
      co2_r   <= co2_nxt;
      temp_r  <= temp_nxt;
      hum_r   <= hum_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // Load the result register at the end of a frame, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_co2_r   <= co2_nxt;
      out_temp_r  <= temp_nxt;
      out_hum_r   <= hum_nxt;
      out_fresh_r <= fresh_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.co2_ppm           = out_co2_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.humidity_centi    = out_hum_r;
  assign out_ch.co2_fresh         = out_fresh_r[0];
  assign out_ch.temperature_fresh = out_fresh_r[1];
  assign out_ch.humidity_fresh    = out_fresh_r[2];

  // Position never leaves the frame
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= smfd_pkg::LAST_POS)
    else $error("byte position beyond frame");

  // The last byte of a frame always produces a pending result and wraps
  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && is_last) |=> (out_valid_r && (pos_r == '0)))
    else $error("frame end did not load result");

  // A frame's first byte never carries a fresh flag forward
  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && (pos_cur == '0)) |=> (fresh_r == 3'b000))
    else $error("fresh flags survived frame start");

  // Held readings stay in range
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hum_r <= smfd_pkg::HUM_MAX) && (temp_r >= smfd_pkg::TEMP_MIN))
    else $error("held reading out of range");

  // A pending result is never overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("result overwritten while pending");

endmodule
